### sv/rsd_pkg.sv
// Package with the shared types and constants of the RMS sound detector.
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;  // a square is at most 2^30
    localparam int QUOT_W      = 31;  // a mean square is at most 2^30
    localparam int RAD_W       = 32;  // radicand padded to an even width
    localparam int ROOT_W      = 16;
    localparam int SREM_W      = 17;  // square root remainder, at most 2 * root
    localparam int THRESHOLD_W = 16;
    localparam int COOLDOWN_W  = 22;
    localparam int ELAPSED_W   = 23;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 1;

    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX     = '1;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = '1;
    localparam logic [COOLDOWN_W-1:0]  COOLDOWN_RESET  = '0;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic JOB_BLOCK = 1'b0;
    localparam logic JOB_TICK  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN  = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rms;
        logic              detected;
    } result_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SQRT,
        B_DONE
    } back_state_t;

endpackage

### sv/rsd_front.sv
// Front end: squares samples, accumulates blocks and queues block and tick jobs.
`timescale 1ns / 1ps

module rsd_front #(
    parameter int MAX_BLOCK = 1024,
    parameter int CNT_W     = 11,
    parameter int SUM_W     = 41,
    parameter int JOB_W     = 53
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rsd_pkg::item_t       item,
    output logic                 push,
    output logic [JOB_W-1:0]     push_data,
    input  logic                 queue_full
);
    import rsd_pkg::*;

    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [2*SAMPLE_W-1:0] product;
    logic [SUM_W-1:0]          sum_add;
    logic [CNT_W-1:0]          count_inc;
    logic                      blk_end;
    logic                      accept;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    // The square of a 16-bit two's complement value is never negative.
    assign product   = item.sample * item.sample;
    assign sum_add   = sum_reg + SUM_W'(product[SQUARE_W-1:0]);
    assign count_inc = count_reg + 1'b1;
    assign blk_end   = item.last || (count_inc == CNT_W'(MAX_BLOCK));

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_data  = {JOB_TICK, {(JOB_W-1){1'b0}}};
        if (accept)
        begin
            if (item.op == OP_TICK)
            begin
                push = 1'b1;
            end
            else if (blk_end)
            begin
                push       = 1'b1;
                push_data  = {JOB_BLOCK, sum_add, count_inc};
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/rsd_queue.sv
// Small first-in first-out job queue between the front and back ends.
`timescale 1ns / 1ps

module rsd_queue #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### sv/rsd_back.sv
// Back end: divides, takes the square root, applies threshold and cooldown.
`timescale 1ns / 1ps

module rsd_back #(
    parameter int CNT_W = 11,
    parameter int SUM_W = 41,
    parameter int JOB_W = 53
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [JOB_W-1:0]                   head,
    input  logic                               queue_empty,
    output logic                               pop,
    input  logic [rsd_pkg::THRESHOLD_W-1:0]    threshold,
    input  logic [rsd_pkg::COOLDOWN_W-1:0]     cooldown_ms,
    output logic                               result_valid,
    input  logic                               result_ready,
    output rsd_pkg::result_t                   result
);
    import rsd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [SUM_W-1:0]      dvd_reg;
    logic [SUM_W-1:0]      dvd_next;
    logic [CNT_W-1:0]      div_reg;
    logic [CNT_W-1:0]      div_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [RAD_W-1:0]      rad_reg;
    logic [RAD_W-1:0]      rad_next;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W-1:0]     root_next;
    logic [SREM_W-1:0]     srem_reg;
    logic [SREM_W-1:0]     srem_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [ELAPSED_W-1:0]  elapsed_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    result_t               res_reg;
    result_t               res_next;

    logic                  job_kind;
    logic [SUM_W-1:0]      job_sum;
    logic [CNT_W-1:0]      job_count;
    logic [CNT_W:0]        rem_sh;
    logic                  q_bit;
    logic [CNT_W:0]        rem_sub;
    logic [SREM_W+1:0]     srem_sh;
    logic [SREM_W+1:0]     trial;
    logic                  r_bit;
    logic [SREM_W+1:0]     srem_sub;
    logic                  det;

    assign {job_kind, job_sum, job_count} = head;

    // One quotient bit per cycle, restoring division.
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, div_reg});
    assign rem_sub = rem_sh - {1'b0, div_reg};

    // One root bit per cycle, two radicand bits brought down each step.
    assign srem_sh  = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = (SREM_W + 2)'({root_reg, 2'b01});
    assign r_bit    = (srem_sh >= trial);
    assign srem_sub = srem_sh - trial;

    assign det = (root_reg >= threshold) && (elapsed_reg > ELAPSED_W'(cooldown_ms));

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        step_next      = step_reg;
        elapsed_next   = elapsed_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (job_kind == JOB_TICK)
                    begin
                        if (elapsed_reg != ELAPSED_MAX)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dvd_next   = job_sum;
                        div_next   = job_count;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                rem_next  = q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    // The mean square fits the low quotient bits.
                    rad_next   = RAD_W'(dvd_next[QUOT_W-1:0]);
                    root_next  = '0;
                    srem_next  = '0;
                    step_next  = '0;
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                srem_next = r_bit ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], r_bit};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next    = 1'b1;
                    res_next.rms      = root_reg;
                    res_next.detected = det;
                    if (det)
                    begin
                        elapsed_next = '0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= ELAPSED_MAX;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg   <= elapsed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

endmodule

### sv/rms_sound_detector_unit.sv
// After the transfer of a block's last sample, its job goes through the job queue and,
// once the back end is free, the bit-serial divider and square root; result_valid then
// rises with the registered result.
// Throughput: one sample per cycle while the job queue has room; the back end takes
// one job at a time from the queue and pops the next only once it is idle again.
// Reset clears the accumulator, queue and result, saturates the elapsed counter,
// and loads threshold 65535 and cooldown 0; no clearing pass is needed.
`timescale 1ns / 1ps

module rms_sound_detector_unit #(
    parameter int MAX_BLOCK = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  rsd_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output rsd_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [rsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rsd_pkg::*;

    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W       = SQUARE_W + CNT_W - 1;
    localparam int JOB_W       = 1 + SUM_W + CNT_W;
    localparam int QUEUE_DEPTH = 4;

    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [COOLDOWN_W-1:0]  cooldown_reg;
    logic                   push;
    logic [JOB_W-1:0]       push_data;
    logic                   pop;
    logic [JOB_W-1:0]       head;
    logic                   queue_empty;
    logic                   queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            cooldown_reg  <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                REG_COOLDOWN:  cooldown_reg  <= cfg_data[COOLDOWN_W-1:0];
                default:       ;
            endcase
        end
    end

    rsd_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .JOB_W     (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    rsd_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    rsd_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .JOB_W (JOB_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .threshold    (threshold_reg),
        .cooldown_ms  (cooldown_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### sv/rsd_checker.sv
// Port-level checker for the RMS sound detector, bound to the top level.
`timescale 1ns / 1ps

module rsd_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  logic             result_ready,
    input  rsd_pkg::result_t result
);
    import rsd_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Reset removes any pending result by the next clock edge.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // The root of a mean of 16-bit squares never exceeds 32768.
    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.rms <= 16'd32768)
        else $error("rms out of range");

endmodule

bind rms_sound_detector_unit rsd_checker u_rsd_checker (.*);

### sim/tb.sv
// Self-checking testbench for the RMS sound detector: random and directed traffic.
`timescale 1ns / 1ps

module tb;

    import rsd_pkg::*;

    localparam int BLOCK_LIMIT  = 1024;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 1500;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_TOP = '1;
    localparam logic [COOLDOWN_W-1:0]  COOLDOWN_TOP  = '1;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Our own copy of the detector state and its registers.
    logic [THRESHOLD_W-1:0] threshold_cfg = THRESHOLD_RESET;
    logic [COOLDOWN_W-1:0]  cooldown_cfg  = COOLDOWN_RESET;
    logic [ELAPSED_W-1:0]   ms_since_hit  = ELAPSED_MAX;
    longint unsigned        square_total  = 0;
    int                     block_len     = 0;

    item_t   pending_items[$];
    result_t expected_levels[$];
    result_t want_level;

    int src_idle_pct = 7;
    int dst_idle_pct = 64;
    int error_count  = 0;
    int cycle_count  = 0;

    logic hold_start = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    rms_sound_detector_unit #(
        .MAX_BLOCK(BLOCK_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = ROOT_W; b >= 0; b--)
        begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r[ROOT_W-1:0];
    endfunction

    // Advances the model by one accepted transfer and queues the block level it yields.
    task automatic predict_level(input item_t it);
        int      amp;
        result_t res;
        if (it.op == OP_TICK)
        begin
            if (ms_since_hit != ELAPSED_MAX)
                ms_since_hit++;
            return;
        end
        amp = $signed(it.sample);
        if (amp < 0)
            amp = -amp;
        square_total += longint'(amp) * longint'(amp);
        block_len++;
        if (!it.last && block_len < BLOCK_LIMIT)
            return;
        res.rms      = root_floor(square_total / longint'(block_len));
        res.detected = 1'b0;
        if (res.rms >= threshold_cfg && ms_since_hit > {1'b0, cooldown_cfg})
        begin
            res.detected = 1'b1;
            ms_since_hit = '0;
        end
        square_total = 0;
        block_len    = 0;
        expected_levels.push_back(res);
    endtask

    // Sender side: a new item is offered only once the previous one has transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_level(item);
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by a toggle of hold_start.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_start != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_start;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= (hold_left == 0) && ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("unexpected result: rms %0d detected %0b", result.rms, result.detected);
                error_count++;
            end
            else
            begin
                want_level = expected_levels.pop_front();
                if (result.rms !== want_level.rms)
                begin
                    $error("rms: expected %0d, got %0d", want_level.rms, result.rms);
                    error_count++;
                end
                if (result.detected !== want_level.detected)
                begin
                    $error("detected: expected %0b, got %0b", want_level.detected,
                           result.detected);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic push_sample(input int value, input logic is_last);
        item_t it;
        it.op     = OP_SAMPLE;
        it.sample = value[SAMPLE_W-1:0];
        it.last   = is_last;
        pending_items.push_back(it);
    endtask

    // Ticks carry random sample and last bits, which the block must ignore.
    task automatic push_tick();
        item_t it;
        it.op     = OP_TICK;
        it.sample = SAMPLE_W'($urandom);
        it.last   = 1'($urandom);
        pending_items.push_back(it);
    endtask

    // Returns once nothing is offered or outstanding and the back end has had time to settle.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD)
            threshold_cfg = val[THRESHOLD_W-1:0];
        else
            cooldown_cfg = val;
        @(negedge clk);
    endtask

    task automatic set_levels(input logic [THRESHOLD_W-1:0] thr, input logic [COOLDOWN_W-1:0] cd);
        wait_idle();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_COOLDOWN, cd);
    endtask

    // Random blocks of mostly short length, with ticks scattered between and inside them.
    task automatic fill_random(input int n_items);
        int                          queued;
        int                          len;
        int                          cls;
        int                          sh;
        logic signed [SAMPLE_W-1:0]  v;
        queued = 0;
        while (queued < n_items)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_tick();
                queued++;
            end
            else
            begin
                len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
                cls = $urandom_range(3);
                sh  = $urandom_range(1, 14);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < 5)
                    begin
                        push_tick();
                        queued++;
                    end
                    case (cls)
                        0: v = SAMPLE_W'($urandom);
                        1:
                        begin
                            v = SAMPLE_W'($urandom);
                            v = v >>> sh;
                        end
                        2:
                        begin
                            case ($urandom_range(4))
                                0: v = -16'sd32768;
                                1: v = 16'sd32767;
                                2: v = 16'sd0;
                                3: v = -16'sd1;
                                default: v = 16'sd1;
                            endcase
                        end
                        default: v = -16'sd32768;
                    endcase
                    push_sample(v, k == len - 1);
                    queued++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: the threshold is out of reach and the elapsed count saturated.
        push_tick();
        push_tick();
        push_sample(32767, 1'b1);
        push_sample(-32768, 1'b1);
        push_sample(0, 1'b1);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(2, 1'b1);
        push_tick();

        // Zero threshold with the longest cooldown: only the first detection fires.
        set_levels('0, COOLDOWN_TOP);
        push_sample(0, 1'b1);
        push_sample(5, 1'b1);
        push_tick();
        push_tick();
        push_tick();

        // Threshold at the largest possible level, no cooldown.
        set_levels(16'd32768, '0);
        push_sample(-32768, 1'b1);
        push_sample(-32768, 1'b1);
        push_tick();
        push_sample(32767, 1'b1);
        push_tick();
        push_sample(-32768, 1'b1);

        // Cooldown boundary: equal elapsed time is not enough.
        set_levels(16'd100, 22'd2);
        push_tick();
        push_tick();
        push_sample(100, 1'b1);
        push_tick();
        push_sample(-100, 1'b1);

        // Full-length block: it ends on its own when it reaches the length limit.
        set_levels(16'd1000, 22'd5);
        for (int i = 0; i < BLOCK_LIMIT; i++)
            push_sample($urandom, 1'b0);
        push_sample(7, 1'b1);

        // Receiver holds off for a long stretch while the sender keeps offering.
        set_levels(16'd5000, 22'd10);
        hold_start = ~hold_start;
        fill_random(175);
        set_levels('0, '0);
        fill_random(175);

        wait_idle();
        src_idle_pct = 64;
        dst_idle_pct = 7;
        set_levels(16'd20000, 22'd3);
        fill_random(175);
        set_levels(THRESHOLD_TOP, COOLDOWN_TOP);
        fill_random(150);

        wait_idle();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_levels(THRESHOLD_W'($urandom_range(32768)), COOLDOWN_W'($urandom_range(40)));
        fill_random(175);
        set_levels(16'd32768, '0);
        fill_random(150);

        wait_idle();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### rms_sound_detector_unit.f
sv/rsd_pkg.sv
sv/rsd_front.sv
sv/rsd_queue.sv
sv/rsd_back.sv
sv/rms_sound_detector_unit.sv
sv/rsd_checker.sv
sim/tb.sv
